// ===== rtl/csf_pkg.sv =====
// ----------------------------------------------------------------------------
// csf_pkg: shared types and constants of the comment strip filter
// Character codes, quote tracking codes and the flag and burst structs
// passed between the step logic and the top level.
// ----------------------------------------------------------------------------
package csf_pkg;

    localparam logic [7:0] CH_BS    = 8'h5C;  // backslash
    localparam logic [7:0] CH_DQ    = 8'h22;  // double quote
    localparam logic [7:0] CH_SQ    = 8'h27;  // single quote
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [2:0] {
        Q_OUT = 3'b001,
        Q_DQ  = 3'b010,
        Q_SQ  = 3'b100
    } quote_t;

    // Fixed-width part of the filter state
    typedef struct packed {
        logic [7:0] held_char;
        logic       held_valid;
        logic       skip_next;
        quote_t     quote;
        logic       escape_pending;
        logic       line_comment;
        logic       backslash_held;
    } csf_flags_t;

    // Output bytes caused by one transaction, in emission order:
    // bs1, run1 (byte1 repeated), bs2, run2 (byte2 repeated), bs3.
    typedef struct packed {
        logic       bs1;
        logic [7:0] byte1;
        logic       bs2;
        logic [7:0] byte2;
        logic       bs3;
        logic       eot;
    } csf_burst_t;

endpackage

// ===== rtl/csf_step.sv =====
// ----------------------------------------------------------------------------
// csf_step: next-state and output burst logic for one input byte
// Runs the comment stripping stage on the delayed byte with the new byte as
// lookahead, then the carriage-return and line-join stage, and flushes on
// the final byte of a text.
// ----------------------------------------------------------------------------
module csf_step
    import csf_pkg::*;
#(
    parameter int MAX_NEST       = 15,
    parameter int MAX_PENDING_NL = 15,
    parameter int DW             = 4,
    parameter int PW             = 4,
    parameter int CW             = 5
) (
    input  csf_flags_t    flags,
    input  logic [DW-1:0] depth,
    input  logic [PW-1:0] pend,
    input  logic [7:0]    in_char,
    input  logic          end_of_text,
    output csf_flags_t    flags_next,
    output logic [DW-1:0] depth_next,
    output logic [PW-1:0] pend_next,
    output csf_burst_t    burst,
    output logic [CW-1:0] cnt1,
    output logic [CW-1:0] cnt2
);

    function automatic void strip_byte(
        input  logic [7:0]    x,
        input  logic          yv,
        input  logic [7:0]    y,
        inout  quote_t        q,
        inout  logic          esc,
        inout  logic          lc,
        inout  logic [DW-1:0] d,
        output logic [7:0]    o,
        output logic          took
    );
        o    = x;
        took = 1'b0;
        if (!lc && d == '0) begin
            if (x == CH_BS) begin
                if (q != Q_OUT) esc = !esc;
            end else begin
                if (x == CH_DQ) begin
                    if (q == Q_OUT) q = Q_DQ;
                    else if (q == Q_DQ && !esc) q = Q_OUT;
                end else if (x == CH_SQ) begin
                    if (q == Q_OUT) q = Q_SQ;
                    else if (q == Q_SQ && !esc) q = Q_OUT;
                end else if (x == CH_NL) begin
                    q = Q_OUT;
                end
                esc = 1'b0;
            end
        end
        if (q == Q_OUT) begin
            if (lc) begin
                if (x == CH_NL) lc = 1'b0;
                else o = CH_SPACE;
            end else if (x == CH_SLASH && yv && y == CH_STAR) begin
                if (d < DW'(MAX_NEST)) d = d + DW'(1);
                took = 1'b1;
                o    = CH_SPACE;
            end else if (d != '0 && x == CH_STAR && yv && y == CH_SLASH) begin
                d    = d - DW'(1);
                took = 1'b1;
                o    = CH_SPACE;
            end else if (d != '0) begin
                if (x != CH_NL) o = CH_SPACE;
            end else if (x == CH_SEMI) begin
                lc = 1'b1;
                o  = CH_SPACE;
            end
        end
    endfunction

    // Drop CR, join backslash-newline, release held newlines before a real one
    function automatic void join_byte(
        input  logic [7:0]    b,
        inout  logic          bs,
        inout  logic [PW-1:0] p,
        output logic          ebs,
        output logic [CW-1:0] cnt
    );
        logic stop;
        stop = 1'b0;
        ebs  = 1'b0;
        cnt  = '0;
        if (bs) begin
            if (b == CH_CR) begin
                stop = 1'b1;
            end else begin
                bs = 1'b0;
                if (b == CH_NL) begin
                    if (p < PW'(MAX_PENDING_NL)) p = p + PW'(1);
                    stop = 1'b1;
                end else begin
                    ebs = 1'b1;
                end
            end
        end
        if (!stop) begin
            if (b == CH_BS) begin
                bs = 1'b1;
            end else if (b == CH_CR) begin
                cnt = '0;
            end else if (b == CH_NL) begin
                cnt = CW'(p) + CW'(1);
                p   = '0;
            end else begin
                cnt = CW'(1);
            end
        end
    endfunction

    always_comb begin
        quote_t        q;
        logic          esc;
        logic          lc;
        logic [DW-1:0] d;
        logic [PW-1:0] p;
        logic          bs;
        logic [7:0]    o1;
        logic [7:0]    o2;
        logic          took1;
        logic          took2;
        logic          ebs1;
        logic          ebs2;
        logic [CW-1:0] c1;
        logic [CW-1:0] c2;

        q     = flags.quote;
        esc   = flags.escape_pending;
        lc    = flags.line_comment;
        d     = depth;
        p     = pend;
        bs    = flags.backslash_held;
        o1    = CH_SPACE;
        o2    = CH_SPACE;
        took1 = 1'b0;
        took2 = 1'b0;
        ebs1  = 1'b0;
        ebs2  = 1'b0;
        c1    = '0;
        c2    = '0;

        // Delayed byte, with the new byte as lookahead
        if (flags.held_valid) begin
            if (!flags.skip_next) begin
                strip_byte(flags.held_char, 1'b1, in_char, q, esc, lc, d, o1, took1);
            end
            join_byte(o1, bs, p, ebs1, c1);
        end

        // Final byte: flush it with no lookahead
        if (end_of_text) begin
            if (!took1) begin
                strip_byte(in_char, 1'b0, 8'h00, q, esc, lc, d, o2, took2);
            end
            join_byte(o2, bs, p, ebs2, c2);
        end

        burst.bs1   = ebs1;
        burst.byte1 = o1;
        burst.bs2   = ebs2;
        burst.byte2 = o2;
        burst.bs3   = end_of_text && bs;
        burst.eot   = end_of_text;
        cnt1        = c1;
        cnt2        = c2;

        if (end_of_text) begin
            flags_next.held_char      = 8'h00;
            flags_next.held_valid     = 1'b0;
            flags_next.skip_next      = 1'b0;
            flags_next.quote          = Q_OUT;
            flags_next.escape_pending = 1'b0;
            flags_next.line_comment   = 1'b0;
            flags_next.backslash_held = 1'b0;
            depth_next                = '0;
            pend_next                 = '0;
        end else begin
            flags_next.held_char      = in_char;
            flags_next.held_valid     = 1'b1;
            flags_next.skip_next      = took1;
            flags_next.quote          = q;
            flags_next.escape_pending = esc;
            flags_next.line_comment   = lc;
            flags_next.backslash_held = bs;
            depth_next                = d;
            pend_next                 = p;
        end
    end

endmodule

// ===== rtl/comment_strip_filter_core.sv =====
// Latency: a byte's cleaned output appears the cycle after the transaction of
//   the following byte (one byte of lookahead); the final byte flushes at once.
// Throughput: one byte per cycle while the sink is ready and each transaction
//   yields at most one byte; a larger burst holds s_ready low until its last byte leaves.
// Reset: aresetn is synchronous, active low, and clears all filter state.
// ----------------------------------------------------------------------------
// comment_strip_filter_core: streaming assembly comment stripper
// Blanks line and nested block comments outside strings, drops carriage
// returns and joins backslash-newline pairs, keeping line numbers.
// ----------------------------------------------------------------------------
module comment_strip_filter_core
    import csf_pkg::*;
#(
    parameter int MAX_NEST       = 15,
    parameter int MAX_PENDING_NL = 15
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_char,
    input  logic       s_end_of_text,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_char,
    output logic       m_last
);

    localparam int DW = $clog2(MAX_NEST + 1);
    localparam int PW = $clog2(MAX_PENDING_NL + 1);
    localparam int CW = $clog2(MAX_PENDING_NL + 2);

    csf_flags_t    flags_reg, flags_next;
    logic [DW-1:0] depth_reg, depth_next;
    logic [PW-1:0] pend_reg, pend_next;
    csf_burst_t    burst_reg, burst_next, step_burst;
    logic [CW-1:0] cnt1_reg, cnt1_next, step_cnt1;
    logic [CW-1:0] cnt2_reg, cnt2_next, step_cnt2;

    logic s_fire;
    logic m_fire;
    logic last_one;
    logic [2:0] n_active;

    csf_step #(
        .MAX_NEST      (MAX_NEST),
        .MAX_PENDING_NL(MAX_PENDING_NL),
        .DW            (DW),
        .PW            (PW),
        .CW            (CW)
    ) u_step (
        .flags      (flags_reg),
        .depth      (depth_reg),
        .pend       (pend_reg),
        .in_char    (s_in_char),
        .end_of_text(s_end_of_text),
        .flags_next (flags_next),
        .depth_next (depth_next),
        .pend_next  (pend_next),
        .burst      (step_burst),
        .cnt1       (step_cnt1),
        .cnt2       (step_cnt2)
    );

    assign n_active = 3'(burst_reg.bs1) + 3'(cnt1_reg != '0) + 3'(burst_reg.bs2)
                    + 3'(cnt2_reg != '0) + 3'(burst_reg.bs3);
    assign last_one = (n_active == 3'd1) && (cnt1_reg < CW'(2)) && (cnt2_reg < CW'(2));

    assign m_valid = (n_active != 3'd0);
    assign m_last  = burst_reg.eot && last_one;
    assign m_fire  = m_valid && m_ready;
    // Take a new transaction once the current burst is gone or leaving now
    assign s_ready = !m_valid || (m_ready && last_one);
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        if (burst_reg.bs1) begin
            m_out_char = CH_BS;
        end else if (cnt1_reg != '0) begin
            m_out_char = burst_reg.byte1;
        end else if (burst_reg.bs2) begin
            m_out_char = CH_BS;
        end else if (cnt2_reg != '0) begin
            m_out_char = burst_reg.byte2;
        end else begin
            m_out_char = CH_BS;
        end
    end

    // Load a burst on a transaction, else drop a backslash or count down a run
    always_comb begin
        burst_next = burst_reg;
        cnt1_next  = cnt1_reg;
        cnt2_next  = cnt2_reg;
        if (s_fire) begin
            burst_next = step_burst;
            cnt1_next  = step_cnt1;
            cnt2_next  = step_cnt2;
        end else if (m_fire) begin
            if (burst_reg.bs1) begin
                burst_next.bs1 = 1'b0;
            end else if (cnt1_reg != '0) begin
                cnt1_next = cnt1_reg - CW'(1);
            end else if (burst_reg.bs2) begin
                burst_next.bs2 = 1'b0;
            end else if (cnt2_reg != '0) begin
                cnt2_next = cnt2_reg - CW'(1);
            end else begin
                burst_next.bs3 = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg.held_char      <= 8'h00;
            flags_reg.held_valid     <= 1'b0;
            flags_reg.skip_next      <= 1'b0;
            flags_reg.quote          <= Q_OUT;
            flags_reg.escape_pending <= 1'b0;
            flags_reg.line_comment   <= 1'b0;
            flags_reg.backslash_held <= 1'b0;
            depth_reg                <= '0;
            pend_reg                 <= '0;
            burst_reg                <= '0;
            cnt1_reg                 <= '0;
            cnt2_reg                 <= '0;
        end else begin
            if (s_fire) begin
                flags_reg <= flags_next;
                depth_reg <= depth_next;
                pend_reg  <= pend_next;
            end
            burst_reg <= burst_next;
            cnt1_reg  <= cnt1_next;
            cnt2_reg  <= cnt2_next;
        end
    end

`ifndef SYNTHESIS
    a_eot_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_end_of_text |=> !flags_reg.held_valid && pend_reg == '0
                                    && depth_reg == '0)
        else $error("state not cleared after final byte");

    a_burst_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_fire && !last_one |=> m_valid)
        else $error("burst lost bytes");

    a_depth_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= DW'(MAX_NEST))
        else $error("nest depth above limit");

    a_pend_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg <= PW'(MAX_PENDING_NL))
        else $error("held newlines above limit");
`endif

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for comment_strip_filter_core
// Texts are fed through the input stream with random source and sink gaps.
// Every byte is predicted at transaction time by a behavioral filter model,
// and each cleaned byte is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
    import csf_pkg::*;

    localparam int          MAX_NEST       = 15;
    localparam int          MAX_PENDING_NL = 15;
    localparam int unsigned CYCLE_LIMIT    = 200000;
    localparam int          DRAIN_CYCLES   = 16;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } clean_byte_t;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_in_char;
    logic       s_end_of_text;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_out_char;
    logic       m_last;

    // filter model state
    logic [7:0] look_char;
    logic       look_valid;
    logic       look_blank;
    quote_t     qmode;
    logic       esc_odd;
    logic       in_line_cmt;
    logic [3:0] blk_depth;
    logic [3:0] joined_nl;
    logic       bs_wait;

    clean_byte_t clean_q[$];
    clean_byte_t step_out[$];
    logic [7:0]  text_buf[$];

    int          errors = 0;
    int          chars_sent = 0;
    int          sink_hold_cycles = 0;
    bit          src_idle_on = 1'b1;
    bit          sink_idle_on = 1'b1;
    int unsigned cycle_count = 0;

    comment_strip_filter_core #(
        .MAX_NEST       (MAX_NEST),
        .MAX_PENDING_NL (MAX_PENDING_NL)
    ) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_char     (s_in_char),
        .s_end_of_text (s_end_of_text),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_char    (m_out_char),
        .m_last        (m_last)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("comment_strip_filter_core verification failed");
            $finish;
        end
    end

    task automatic log_error(input string what);
        errors++;
        if (errors <= 10)
            $display("ERROR at %0t: %s", $time, what);
    endtask

    // ------------------------------------------------------------------
    // Filter model
    // ------------------------------------------------------------------
    function automatic void clear_filter();
        look_char   = 8'h00;
        look_valid  = 1'b0;
        look_blank  = 1'b0;
        qmode       = Q_OUT;
        esc_odd     = 1'b0;
        in_line_cmt = 1'b0;
        blk_depth   = 4'd0;
        joined_nl   = 4'd0;
        bs_wait     = 1'b0;
    endfunction

    // Second stage: drop CR, join backslash-newline, replay joined newlines.
    function automatic void join_byte(input logic [7:0] b);
        if (bs_wait) begin
            if (b == CH_CR)
                return;
            bs_wait = 1'b0;
            if (b == CH_NL) begin
                if (joined_nl < MAX_PENDING_NL)
                    joined_nl++;
                return;
            end
            step_out.push_back({CH_BS, 1'b0});
        end
        if (b == CH_BS) begin
            bs_wait = 1'b1;
        end else if (b == CH_NL) begin
            while (joined_nl > 0) begin
                step_out.push_back({CH_NL, 1'b0});
                joined_nl--;
            end
            step_out.push_back({CH_NL, 1'b0});
        end else if (b != CH_CR) begin
            step_out.push_back({b, 1'b0});
        end
    endfunction

    function automatic void follow_quotes(input logic [7:0] c);
        if (c == CH_BS) begin
            if (qmode != Q_OUT)
                esc_odd = !esc_odd;
            return;
        end
        if (c == CH_DQ) begin
            if (qmode == Q_OUT)
                qmode = Q_DQ;
            else if (qmode == Q_DQ && !esc_odd)
                qmode = Q_OUT;
        end else if (c == CH_SQ) begin
            if (qmode == Q_OUT)
                qmode = Q_SQ;
            else if (qmode == Q_SQ && !esc_odd)
                qmode = Q_OUT;
        end else if (c == CH_NL) begin
            qmode = Q_OUT;
        end
        esc_odd = 1'b0;
    endfunction

    // First stage: blank comments in x; report whether y completed a delimiter.
    function automatic logic strip_byte(input logic [7:0] x, input logic y_ok,
                                        input logic [7:0] y);
        logic [7:0] o;
        logic       took;
        o    = x;
        took = 1'b0;
        if (!in_line_cmt && blk_depth == 0)
            follow_quotes(x);
        if (qmode == Q_OUT) begin
            if (in_line_cmt) begin
                if (x == CH_NL)
                    in_line_cmt = 1'b0;
                else
                    o = CH_SPACE;
            end else if (x == CH_SLASH && y_ok && y == CH_STAR) begin
                if (blk_depth < MAX_NEST)
                    blk_depth++;
                took = 1'b1;
                o    = CH_SPACE;
            end else if (blk_depth > 0 && x == CH_STAR && y_ok && y == CH_SLASH) begin
                blk_depth--;
                took = 1'b1;
                o    = CH_SPACE;
            end else if (blk_depth > 0) begin
                if (x != CH_NL)
                    o = CH_SPACE;
            end else if (x == CH_SEMI) begin
                in_line_cmt = 1'b1;
                o           = CH_SPACE;
            end
        end
        join_byte(o);
        return took;
    endfunction

    function automatic void predict_char(input logic [7:0] c, input logic eot);
        logic blank_next;
        blank_next = 1'b0;
        step_out.delete();
        if (look_valid) begin
            if (look_blank)
                join_byte(CH_SPACE);
            else
                blank_next = strip_byte(look_char, 1'b1, c);
        end
        look_char  = c;
        look_valid = 1'b1;
        look_blank = blank_next;
        if (eot) begin
            if (look_blank)
                join_byte(CH_SPACE);
            else
                void'(strip_byte(c, 1'b0, 8'h00));
            if (bs_wait)
                step_out.push_back({CH_BS, 1'b0});
            if (step_out.size() > 0)
                step_out[step_out.size() - 1].last = 1'b1;
            clear_filter();
        end
        foreach (step_out[i])
            clean_q.push_back(step_out[i]);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    // Call at a rising edge; returns at the edge where the transaction completes.
    task automatic send_char(input logic [7:0] c, input logic eot);
        while (src_idle_on && $urandom_range(99) < 17) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_in_char     <= c;
        s_end_of_text <= eot;
        predict_char(c, eot);
        chars_sent++;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_text();
        foreach (text_buf[i])
            send_char(text_buf[i], i == text_buf.size() - 1);
        text_buf.delete();
    endtask

    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++)
            text_buf.push_back(s[i]);
    endtask

    task automatic add_token();
        int pick;
        int n;
        pick = $urandom_range(99);
        n    = $urandom_range(18, 14);
        if (pick < 25) begin
            text_buf.push_back(8'($urandom_range(8'h7a, 8'h61)));
        end else if (pick < 35) begin
            text_buf.push_back(8'($urandom_range(255)));
        end else if (pick < 43) begin
            text_buf.push_back(CH_SEMI);
        end else if (pick < 50) begin
            text_buf.push_back(CH_SLASH);
            text_buf.push_back(CH_STAR);
        end else if (pick < 57) begin
            text_buf.push_back(CH_STAR);
            text_buf.push_back(CH_SLASH);
        end else if (pick < 63) begin
            text_buf.push_back(CH_DQ);
        end else if (pick < 69) begin
            text_buf.push_back(CH_SQ);
        end else if (pick < 75) begin
            text_buf.push_back(CH_BS);
        end else if (pick < 80) begin
            text_buf.push_back(CH_CR);
        end else if (pick < 88) begin
            text_buf.push_back(CH_NL);
        end else if (pick < 93) begin
            text_buf.push_back(CH_BS);
            text_buf.push_back(CH_NL);
        end else if (pick < 96) begin
            text_buf.push_back(CH_BS);
            text_buf.push_back(CH_CR);
            text_buf.push_back(CH_NL);
        end else if (pick < 98) begin
            text_buf.push_back($urandom_range(1) ? CH_SLASH : CH_STAR);
        end else if (pick == 98) begin
            // push nesting toward saturation
            repeat (n) begin
                text_buf.push_back(CH_SLASH);
                text_buf.push_back(CH_STAR);
            end
        end else begin
            repeat (n) begin
                text_buf.push_back(CH_BS);
                text_buf.push_back(CH_NL);
            end
        end
    endtask

    task automatic send_random_texts(input int count);
        int stop_at;
        stop_at = chars_sent + count;
        while (chars_sent < stop_at) begin
            repeat ($urandom_range(20, 1)) add_token();
            send_text();
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        text_buf = '{8'h00, 8'hff};
        send_text();
        // delimiters inside a line comment, newline ends it
        add_str(";a/*");
        text_buf.push_back(CH_NL);
        add_str("b");
        send_text();
        // slash right after the opener does not close
        add_str("/*/;*/c");
        send_text();
        // other quote literal, escaped quote, semicolon in string
        add_str("\"'\\\"';\"x");
        send_text();
        // even backslash run lets the quote close
        add_str("'\\\\'x");
        send_text();
        // joins with CR, CR dropped, held newline replayed, trailing backslash
        add_str("a");
        text_buf.push_back(CH_BS);
        text_buf.push_back(CH_CR);
        text_buf.push_back(CH_NL);
        text_buf.push_back(CH_CR);
        text_buf.push_back(CH_NL);
        add_str("b\\");
        send_text();
        // final step yields nothing
        add_str("a");
        text_buf.push_back(CH_CR);
        text_buf.push_back(CH_CR);
        send_text();
    endtask

    task automatic test_saturation();
        repeat (MAX_NEST + 1) add_str("/*");
        add_str("x");
        text_buf.push_back(CH_NL);
        repeat (MAX_NEST + 1) add_str("*/");
        add_str("y");
        send_text();
        repeat (MAX_PENDING_NL + 1) begin
            text_buf.push_back(CH_BS);
            text_buf.push_back(CH_NL);
        end
        add_str("k");
        text_buf.push_back(CH_NL);
        repeat (3) begin
            text_buf.push_back(CH_BS);
            text_buf.push_back(CH_NL);
        end
        send_text();
    endtask

    task automatic test_full_rate();
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        send_random_texts(80);
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
    endtask

    task automatic test_backpressure();
        sink_hold_cycles = 300;
        while (text_buf.size() < 50)
            add_token();
        send_text();
    endtask

    task automatic test_random();
        send_random_texts(170);
    endtask

    // ------------------------------------------------------------------
    // Sink and checker
    // ------------------------------------------------------------------
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (sink_hold_cycles > 0) begin
                m_ready <= 1'b0;
                sink_hold_cycles--;
            end else begin
                m_ready <= !(sink_idle_on && $urandom_range(99) < 17);
            end
        end
    end

    always @(posedge aclk) begin : check_out
        clean_byte_t want;
        if (aresetn && m_valid && m_ready) begin
            if (clean_q.size() == 0) begin
                log_error($sformatf("unexpected byte %02h last %0b", m_out_char, m_last));
            end else begin
                want = clean_q.pop_front();
                if (m_out_char !== want.ch)
                    log_error($sformatf("out_char expected %02h got %02h",
                                        want.ch, m_out_char));
                if (m_last !== want.last)
                    log_error($sformatf("last expected %0b got %0b (char %02h)",
                                        want.last, m_last, want.ch));
            end
        end
    end

    initial begin : main
        int guard;
        aresetn       <= 1'b0;
        s_valid       <= 1'b0;
        s_in_char     <= 8'h00;
        s_end_of_text <= 1'b0;
        clear_filter();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_saturation();
        test_full_rate();
        test_backpressure();
        test_random();

        s_valid <= 1'b0;
        for (guard = 0; guard < 5000 && clean_q.size() != 0; guard++)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (clean_q.size() != 0)
            log_error($sformatf("%0d expected bytes never arrived", clean_q.size()));

        if (errors == 0)
            $display("comment_strip_filter_core verification clean");
        else
            $display("comment_strip_filter_core verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/csf_pkg.sv
rtl/csf_step.sv
rtl/comment_strip_filter_core.sv
tb/tb_top.sv
